/* rtl/mtw_pkg.sv */
// Shared types, constants and helpers for the metatile tilemap writer.
// Used by the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtw_pkg;

   localparam int unsigned LEVEL_BYTES_DEF = 4096;
   localparam int unsigned CHUNK_COUNT_DEF = 256;
   localparam int unsigned BLOCK_COUNT_DEF = 1024;
   localparam int unsigned RING_BLOCKS_DEF = 32;

   localparam int unsigned CHUNK_WORDS    = 64;
   localparam int unsigned BLOCK_CELLS    = 4;
   localparam int unsigned LEVEL_ROW_SPAN = 256;
   localparam int unsigned CHUNK_SIDE     = 8;
   localparam int unsigned BLOCK_INDEX_W  = 10;
   localparam int unsigned FLIP_SHIFT     = 30;

   localparam logic [31:0] CELL_BASE = 32'h0000_1000;

   typedef enum logic [1:0] {
      OP_WR_LEVEL = 2'd0,
      OP_WR_CHUNK = 2'd1,
      OP_WR_BLOCK = 2'd2,
      OP_PLACE    = 2'd3
   } op_type;

   // Remainder by shift-and-subtract; covers values up to 511 times the modulus.
   function automatic logic [11:0] mod_reduce(input logic [11:0] value,
                                              input int unsigned modulus);
      logic [20:0] rem;
      logic [20:0] step;
      rem = {9'd0, value};
      for (int i = 8; i >= 0; i--) begin
         step = 21'(modulus << i);
         if (rem >= step) begin
            rem = rem - step;
         end
      end
      return rem[11:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/mtw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-during-write to the same entry returns the old contents. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mtw_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/metatile_tilemap_writer.sv */
// Metatile tilemap writer top level: level map, chunk and block tables in RAM.
// Depends on mtw_pkg and mtw_ram.
//
// A transaction is taken at a clock edge where start is high and busy is low. Table
// writes (level byte, chunk word, block cell word) are taken every cycle while busy is
// low and give no result; an index beyond a table is ignored. A placement raises busy
// to hold off the next transaction, the pace of the single read port of the block
// table, which fetches one cell word per cycle. The four tilemap writes of a placement
// appear on rsp_valid on consecutive cycles, after the level, chunk, cell sequencer,
// issue and output registers, rsp_last marking the fourth. A placement at a negative
// tile coordinate that is not a multiple of RING_BLOCKS gives no result. The receiver
// cannot stall the results. Tables hold no defined contents after reset: every entry
// must be written before a placement reads it; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module metatile_tilemap_writer
   import mtw_pkg::*;
#(
   parameter int unsigned LEVEL_BYTES = LEVEL_BYTES_DEF,
   parameter int unsigned CHUNK_COUNT = CHUNK_COUNT_DEF,
   parameter int unsigned BLOCK_COUNT = BLOCK_COUNT_DEF,
   parameter int unsigned RING_BLOCKS = RING_BLOCKS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [1:0]         req_operation,
   input  wire logic               req_layer,
   input  wire logic signed [11:0] req_tile_x,
   input  wire logic signed [11:0] req_tile_y,
   input  wire logic [13:0]        req_table_index,
   input  wire logic [31:0]        req_table_value,
   output      logic               rsp_valid,
   output      logic               rsp_out_layer,
   output      logic [11:0]        rsp_cell_address,
   output      logic [31:0]        rsp_cell_word,
   output      logic               rsp_last
);

   localparam int unsigned LA          = $clog2(LEVEL_BYTES);
   localparam int unsigned CHUNK_DEPTH = CHUNK_COUNT * CHUNK_WORDS;
   localparam int unsigned CA          = $clog2(CHUNK_DEPTH);
   localparam int unsigned BLOCK_DEPTH = BLOCK_COUNT * BLOCK_CELLS;
   localparam int unsigned BA          = $clog2(BLOCK_DEPTH);
   localparam int unsigned MAP_ROWS    = (LEVEL_BYTES / LEVEL_ROW_SPAN) * CHUNK_SIDE;
   localparam int unsigned RW          = $clog2(RING_BLOCKS);

   // accept stage
   logic            accept;
   logic [1:0]      busy_cnt_ff, busy_cnt_in;
   logic            lvl_we;
   logic [LA-1:0]   lvl_rd_addr;
   logic [7:0]      lvl_rd_data;

   // level stage
   logic              b_valid_ff;
   op_type            b_op_ff;
   logic              b_layer_ff;
   logic signed [11:0] b_tx_ff, b_ty_ff;
   logic [13:0]       b_idx_ff;
   logic [31:0]       b_val_ff;
   logic [11:0]       mag_x, mag_y, rem_x, rem_y;
   logic [11:0]       chunk_full;
   logic              b_drop, b_in_map;
   logic              chk_we;
   logic [CA-1:0]     chk_rd_addr;
   logic [15:0]       chk_rd_data;

   // chunk stage
   logic              c_valid_ff;
   op_type            c_op_ff;
   logic              c_layer_ff;
   logic              c_in_map_ff;
   logic              c_drop_ff;
   logic [RW-1:0]     c_rx_ff, c_ry_ff;
   logic [13:0]       c_idx_ff;
   logic [31:0]       c_val_ff;
   logic [15:0]       c_word;
   logic [11:0]       c_bidx;
   logic              c_start;
   logic              blk_we;

   // cell sequencer
   logic              seq_active_ff, seq_active_in;
   logic [1:0]        seq_k_ff, seq_k_in;
   logic [BA-3:0]     seq_bidx_ff;
   logic [1:0]        seq_mirror_ff;
   logic              seq_layer_ff;
   logic [RW-1:0]     seq_rx_ff, seq_ry_ff;
   logic [BA-1:0]     blk_rd_addr;
   logic [31:0]       blk_rd_data;
   logic [6:0]        seq_row, seq_col;
   logic [11:0]       seq_addr;

   // issue and output stages
   logic              p_valid_ff;
   logic              p_layer_ff;
   logic [11:0]       p_addr_ff;
   logic [1:0]        p_flip_ff;
   logic              p_last_ff;
   logic              rsp_valid_ff;
   logic              rsp_layer_ff;
   logic [11:0]       rsp_addr_ff;
   logic [31:0]       rsp_word_ff, rsp_word_in;
   logic              rsp_last_ff;

   // ---------------- accept stage ----------------
   assign busy   = (busy_cnt_ff != 2'd0);
   assign accept = start && !busy;

   always_comb begin
      busy_cnt_in = busy_cnt_ff;
      if (accept && (op_type'(req_operation) == OP_PLACE)) begin
         busy_cnt_in = 2'd3;
      end else if (busy_cnt_ff != 2'd0) begin
         busy_cnt_in = busy_cnt_ff - 2'd1;
      end
   end

   assign lvl_we = accept && (op_type'(req_operation) == OP_WR_LEVEL)
                   && ({3'd0, req_table_index} < 17'(LEVEL_BYTES));
   assign lvl_rd_addr = LA'({req_tile_y[11:3], req_layer, req_tile_x[9:3]});

   mtw_ram #(
      .WIDTH (8),
      .DEPTH (LEVEL_BYTES)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (LA'(req_table_index)),
      .wr_data (req_table_value[7:0]),
      .rd_addr (lvl_rd_addr),
      .rd_data (lvl_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_cnt_ff <= 2'd0;
         b_valid_ff  <= 1'b0;
      end else begin
         busy_cnt_ff <= busy_cnt_in;
         b_valid_ff  <= accept;
      end
      b_op_ff    <= op_type'(req_operation);
      b_layer_ff <= req_layer;
      b_tx_ff    <= req_tile_x;
      b_ty_ff    <= req_tile_y;
      b_idx_ff   <= req_table_index;
      b_val_ff   <= req_table_value;
   end

   // ---------------- level stage ----------------
   always_comb begin
      mag_x      = b_tx_ff[11] ? 12'(-b_tx_ff) : 12'(b_tx_ff);
      mag_y      = b_ty_ff[11] ? 12'(-b_ty_ff) : 12'(b_ty_ff);
      rem_x      = mod_reduce(mag_x, RING_BLOCKS);
      rem_y      = mod_reduce(mag_y, RING_BLOCKS);
      b_drop     = (b_tx_ff[11] && (rem_x != 12'd0)) || (b_ty_ff[11] && (rem_y != 12'd0));
      b_in_map   = (b_tx_ff[11:10] == 2'b00) && !b_ty_ff[11]
                   && ({1'b0, b_ty_ff[10:0]} < 12'(MAP_ROWS));
      chunk_full = mod_reduce({4'd0, lvl_rd_data}, CHUNK_COUNT);
      chk_rd_addr = CA'({chunk_full[7:0], b_ty_ff[2:0], b_tx_ff[2:0]});
   end

   assign chk_we = b_valid_ff && (b_op_ff == OP_WR_CHUNK)
                   && ({1'b0, b_idx_ff} < 15'(CHUNK_DEPTH));

   mtw_ram #(
      .WIDTH (16),
      .DEPTH (CHUNK_DEPTH)
   ) u_chunk_ram (
      .clock   (clock),
      .wr_en   (chk_we),
      .wr_addr (CA'(b_idx_ff)),
      .wr_data (b_val_ff[15:0]),
      .rd_addr (chk_rd_addr),
      .rd_data (chk_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_op_ff     <= b_op_ff;
      c_layer_ff  <= b_layer_ff;
      c_in_map_ff <= b_in_map;
      c_drop_ff   <= b_drop;
      c_rx_ff     <= RW'(rem_x);
      c_ry_ff     <= RW'(rem_y);
      c_idx_ff    <= b_idx_ff;
      c_val_ff    <= b_val_ff;
   end

   // ---------------- chunk stage ----------------
   assign c_word  = c_in_map_ff ? chk_rd_data : 16'd0;
   assign c_bidx  = mod_reduce({2'd0, c_word[BLOCK_INDEX_W-1:0]}, BLOCK_COUNT);
   assign c_start = c_valid_ff && (c_op_ff == OP_PLACE) && !c_drop_ff;
   assign blk_we  = c_valid_ff && (c_op_ff == OP_WR_BLOCK)
                    && ({1'b0, c_idx_ff} < 15'(BLOCK_DEPTH));

   always_comb begin
      seq_active_in = seq_active_ff;
      seq_k_in      = seq_k_ff;
      if (c_start) begin
         seq_active_in = 1'b1;
         seq_k_in      = 2'd0;
      end else if (seq_active_ff) begin
         seq_active_in = (seq_k_ff != 2'd3);
         seq_k_in      = seq_k_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_active_ff <= 1'b0;
         seq_k_ff      <= 2'd0;
      end else begin
         seq_active_ff <= seq_active_in;
         seq_k_ff      <= seq_k_in;
      end
      if (c_start) begin
         seq_bidx_ff   <= (BA-2)'(c_bidx);
         seq_mirror_ff <= c_word[BLOCK_INDEX_W +: 2];
         seq_layer_ff  <= c_layer_ff;
         seq_rx_ff     <= c_rx_ff;
         seq_ry_ff     <= c_ry_ff;
      end
   end

   // ---------------- cell fetch ----------------
   assign blk_rd_addr = {seq_bidx_ff, seq_k_ff ^ seq_mirror_ff};
   assign seq_row     = 7'({seq_ry_ff, 1'b0}) | 7'(seq_k_ff[1]);
   assign seq_col     = 7'({seq_rx_ff, 1'b0}) | 7'(seq_k_ff[0]);
   assign seq_addr    = {seq_row[5:0], 6'd0} + {5'd0, seq_col};

   mtw_ram #(
      .WIDTH (32),
      .DEPTH (BLOCK_DEPTH)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_addr (BA'(c_idx_ff)),
      .wr_data (c_val_ff),
      .rd_addr (blk_rd_addr),
      .rd_data (blk_rd_data)
   );

   assign rsp_word_in = (blk_rd_data | CELL_BASE) ^ (32'(p_flip_ff) << FLIP_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= seq_active_ff;
         rsp_valid_ff <= p_valid_ff;
      end
      p_layer_ff   <= seq_layer_ff;
      p_addr_ff    <= seq_addr;
      p_flip_ff    <= seq_mirror_ff;
      p_last_ff    <= (seq_k_ff == 2'd3);
      rsp_layer_ff <= p_layer_ff;
      rsp_addr_ff  <= p_addr_ff;
      rsp_word_ff  <= rsp_word_in;
      rsp_last_ff  <= p_last_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_layer    = rsp_layer_ff;
   assign rsp_cell_address = rsp_addr_ff;
   assign rsp_cell_word    = rsp_word_ff;
   assign rsp_last         = rsp_last_ff && rsp_valid_ff;

`ifndef SYNTHESIS
   a_place_holds_off: assert property (@(posedge clock) disable iff (reset)
      (accept && (op_type'(req_operation) == OP_PLACE)) |=> busy)
      else $error("placement taken without holding off the next transaction");

   a_seq_no_overlap: assert property (@(posedge clock) disable iff (reset)
      c_start |-> (!seq_active_ff || (seq_k_ff == 2'd3)))
      else $error("placement reached the cell fetch while another was running");

   a_burst_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> ($past(rsp_valid_ff, 3) && !$past(rsp_last_ff, 1)))
      else $error("last cell write without the three before it");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |=> rsp_valid_ff)
      else $error("cell write burst broken before its last write");
`endif

endmodule

`default_nettype wire
